/* src/assert_macros.svh */
// assertion macros shared by the envelope evaluator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define PLEEV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a property in the next
`define PLEEV_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* src/pleev_pkg.sv */
// shared constants and types of the particle life envelope evaluator
package pleev_pkg;

    localparam int AGE_FRACTION_BITS   = 8;
    localparam int BLEND_FRACTION_BITS = 16;

    localparam int AGE_W       = 17;
    localparam int FRAMES_W    = 8;
    localparam int BYTE_W      = 8;
    localparam int WIDTH_W     = 25;
    localparam int POINT_W     = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam int LIFE_Q_W  = FRAMES_W + AGE_FRACTION_BITS;
    localparam int DIV_SHIFT = BLEND_FRACTION_BITS - AGE_FRACTION_BITS;
    localparam int T_W       = BLEND_FRACTION_BITS + 1;
    localparam int PROD_W    = WIDTH_W + T_W;

    localparam int COLOUR_LANES = 4;
    localparam int LANES        = COLOUR_LANES + 1;
    localparam int WIDTH_LANE   = COLOUR_LANES;
    localparam int ENV_POINTS   = 4;

    localparam int PT_LIFE_START = 0;
    localparam int PT_LIFE_END   = 1;
    localparam int PT_FADE_START = 2;
    localparam int PT_FADE_END   = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIDTH_W-1:0] WIDTH_MOST = 25'd25600000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LIFE_FRAMES       = 3'd0,
        CFG_FADE_FRAMES       = 3'd1,
        CFG_RED_ENVELOPE      = 3'd2,
        CFG_GREEN_ENVELOPE    = 3'd3,
        CFG_BLUE_ENVELOPE     = 3'd4,
        CFG_ALPHA_ENVELOPE    = 3'd5,
        CFG_WIDTH_LIFE_POINTS = 3'd6,
        CFG_WIDTH_FADE_POINTS = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [FRAMES_W-1:0]                               life_frames;
        logic [FRAMES_W-1:0]                               fade_frames;
        logic [COLOUR_LANES-1:0][ENV_POINTS-1:0][BYTE_W-1:0] colour_env;
        logic [CFG_DATA_W-1:0]                             width_life;
        logic [CFG_DATA_W-1:0]                             width_fade;
    } cfg_t;

    typedef struct packed {
        logic             fading;
        logic             saturate;
        logic [AGE_W-1:0] numer;
    } job_t;

    typedef struct packed {
        logic [QUEUE_CNT_W-1:0] count;
        logic                   full;
        logic                   empty;
    } queue_status_t;

endpackage

/* src/pleev_ifs.sv */
// request channels of the envelope evaluator
interface pleev_age_if;
    logic                          valid;
    logic                          ready;
    logic [pleev_pkg::AGE_W-1:0]   particle_age;

    modport source (output valid, output particle_age, input ready);
    modport sink (input valid, input particle_age, output ready);
endinterface

interface pleev_result_if;
    logic                          valid;
    logic                          ready;
    logic [pleev_pkg::BYTE_W-1:0]  red_out;
    logic [pleev_pkg::BYTE_W-1:0]  green_out;
    logic [pleev_pkg::BYTE_W-1:0]  blue_out;
    logic [pleev_pkg::BYTE_W-1:0]  alpha_out;
    logic [pleev_pkg::WIDTH_W-1:0] width_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, output width_out, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, input width_out, output ready);
endinterface

interface pleev_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pleev_pkg::CFG_INDEX_W-1:0] index;
    logic [pleev_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* src/pleev_front.sv */
// front end: accepts ages and classifies them into life or fade jobs
module pleev_front (
    pleev_age_if.sink                age,
    input  pleev_pkg::cfg_t          cfg,
    input  pleev_pkg::queue_status_t q_status,
    output logic                     push,
    output pleev_pkg::job_t          job
);

    logic [pleev_pkg::LIFE_Q_W-1:0] life_q;
    logic [pleev_pkg::LIFE_Q_W-1:0] fade_q;
    logic [pleev_pkg::AGE_W-1:0]    diff;
    logic                           in_life;
    logic                           past_fade;

    assign life_q = {cfg.life_frames, {pleev_pkg::AGE_FRACTION_BITS{1'b0}}};
    assign fade_q = {cfg.fade_frames, {pleev_pkg::AGE_FRACTION_BITS{1'b0}}};

    assign in_life   = age.particle_age < pleev_pkg::AGE_W'(life_q);
    assign diff      = age.particle_age - pleev_pkg::AGE_W'(life_q);
    assign past_fade = (cfg.fade_frames == '0) || (diff >= pleev_pkg::AGE_W'(fade_q));

    assign age.ready = !q_status.full;
    assign push      = age.valid && !q_status.full;

    always_comb
    begin
        job.fading   = !in_life;
        job.saturate = !in_life && past_fade;
        job.numer    = in_life ? age.particle_age : diff;
    end

endmodule

/* src/pleev_queue.sv */
// short job queue between front and back end
module pleev_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  pleev_pkg::job_t          push_job,
    input  logic                     pop,
    output pleev_pkg::job_t          head,
    output pleev_pkg::queue_status_t status
);

    pleev_pkg::job_t                   entries_reg [pleev_pkg::QUEUE_DEPTH];
    logic [pleev_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [pleev_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [pleev_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [pleev_pkg::QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [pleev_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [pleev_pkg::QUEUE_CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == pleev_pkg::QUEUE_PTR_W'(pleev_pkg::QUEUE_DEPTH - 1))
                ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pleev_pkg::QUEUE_PTR_W'(pleev_pkg::QUEUE_DEPTH - 1))
                ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head         = entries_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.full  = count_reg == pleev_pkg::QUEUE_CNT_W'(pleev_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;

endmodule

/* src/pleev_back.sv */
// back end: pipelined fraction divider and five blending lanes
module pleev_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pleev_pkg::cfg_t          cfg,
    input  pleev_pkg::queue_status_t q_status,
    input  pleev_pkg::job_t          head,
    output logic                     pop,
    pleev_result_if.source           result
);

    localparam int DIV_STAGES = pleev_pkg::BLEND_FRACTION_BITS;
    localparam int BF         = pleev_pkg::BLEND_FRACTION_BITS;

    localparam logic [pleev_pkg::T_W-1:0]      T_ONE = {1'b1, {BF{1'b0}}};
    localparam logic [pleev_pkg::PROD_W:0]     ROUND_UP = {{(pleev_pkg::PROD_W + 1 - BF){1'b0}},
                                                           {BF{1'b1}}};

    typedef struct packed {
        logic                          fading;
        logic                          saturate;
        logic [pleev_pkg::FRAMES_W-1:0] rem;
        logic [BF-1:0]                 dq;
    } div_t;

    function automatic div_t div_step(div_t s, logic [pleev_pkg::FRAMES_W-1:0] d);
        div_t                           r;
        logic [pleev_pkg::FRAMES_W:0]   trial;
        r     = s;
        trial = {s.rem, s.dq[BF-1]};
        r.dq  = {s.dq[BF-2:0], 1'b0};
        if (trial >= {1'b0, d})
        begin
            trial   = trial - {1'b0, d};
            r.dq[0] = 1'b1;
        end
        r.rem = trial[pleev_pkg::FRAMES_W-1:0];
        return r;
    endfunction

    function automatic logic [pleev_pkg::WIDTH_W-1:0] clip_width(
        logic [pleev_pkg::POINT_W-1:0] v);
        if (v > pleev_pkg::POINT_W'(pleev_pkg::WIDTH_MOST))
        begin
            return pleev_pkg::WIDTH_MOST;
        end
        return v[pleev_pkg::WIDTH_W-1:0];
    endfunction

    logic                              en;
    logic [DIV_STAGES:0]               div_valid_reg;
    div_t                              div_reg  [DIV_STAGES+1];
    div_t                              div_next [DIV_STAGES+1];
    logic                              mul_valid_reg;
    logic                              out_valid_reg;

    logic [pleev_pkg::T_W-1:0]         t;
    logic                              lane_fading;
    logic [pleev_pkg::CFG_DATA_W-1:0]  width_pair;
    logic [pleev_pkg::WIDTH_W-1:0]     pa [pleev_pkg::LANES];
    logic [pleev_pkg::WIDTH_W-1:0]     pb [pleev_pkg::LANES];
    logic                              up_next   [pleev_pkg::LANES];
    logic [pleev_pkg::WIDTH_W-1:0]     mag       [pleev_pkg::LANES];
    logic [pleev_pkg::PROD_W-1:0]      prod_next [pleev_pkg::LANES];
    logic [pleev_pkg::PROD_W-1:0]      prod_reg  [pleev_pkg::LANES];
    logic [pleev_pkg::WIDTH_W-1:0]     base_reg  [pleev_pkg::LANES];
    logic                              up_reg    [pleev_pkg::LANES];
    logic [pleev_pkg::PROD_W:0]        down_sum  [pleev_pkg::LANES];
    logic [pleev_pkg::WIDTH_W-1:0]     res_next  [pleev_pkg::LANES];
    logic [pleev_pkg::WIDTH_W-1:0]     res_reg   [pleev_pkg::LANES];

    assign en  = !out_valid_reg || result.ready;
    assign pop = en && !q_status.empty;

    // divider load and one quotient bit per stage
    assign div_next[0] = {head.fading, head.saturate,
                          pleev_pkg::FRAMES_W'(head.numer >> pleev_pkg::AGE_FRACTION_BITS),
                          BF'((pleev_pkg::AGE_W + BF)'(head.numer) << pleev_pkg::DIV_SHIFT)};

    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_div
        assign div_next[k] = div_step(div_reg[k-1],
            div_reg[k-1].fading ? cfg.fade_frames : cfg.life_frames);
    end

    // lane end points and multiply
    always_comb
    begin
        lane_fading = div_reg[DIV_STAGES].fading;
        t = div_reg[DIV_STAGES].saturate ? T_ONE : {1'b0, div_reg[DIV_STAGES].dq};
        for (int i = 0; i < pleev_pkg::COLOUR_LANES; i++)
        begin
            pa[i] = pleev_pkg::WIDTH_W'(lane_fading ? cfg.colour_env[i][pleev_pkg::PT_FADE_START]
                                                    : cfg.colour_env[i][pleev_pkg::PT_LIFE_START]);
            pb[i] = pleev_pkg::WIDTH_W'(lane_fading ? cfg.colour_env[i][pleev_pkg::PT_FADE_END]
                                                    : cfg.colour_env[i][pleev_pkg::PT_LIFE_END]);
        end
        width_pair = lane_fading ? cfg.width_fade : cfg.width_life;
        pa[pleev_pkg::WIDTH_LANE] = clip_width(width_pair[pleev_pkg::POINT_W-1:0]);
        pb[pleev_pkg::WIDTH_LANE] = clip_width(width_pair[pleev_pkg::CFG_DATA_W-1:
                                                          pleev_pkg::POINT_W]);
        for (int i = 0; i < pleev_pkg::LANES; i++)
        begin
            up_next[i]   = pb[i] >= pa[i];
            mag[i]       = up_next[i] ? pb[i] - pa[i] : pa[i] - pb[i];
            prod_next[i] = pleev_pkg::PROD_W'(mag[i]) * pleev_pkg::PROD_W'(t);
        end
    end

    // floor of the blended value
    always_comb
    begin
        for (int i = 0; i < pleev_pkg::LANES; i++)
        begin
            down_sum[i] = {1'b0, prod_reg[i]} + ROUND_UP;
            res_next[i] = up_reg[i]
                ? base_reg[i] + pleev_pkg::WIDTH_W'(prod_reg[i] >> BF)
                : base_reg[i] - pleev_pkg::WIDTH_W'(down_sum[i] >> BF);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg <= '0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            div_valid_reg <= {div_valid_reg[DIV_STAGES-1:0], pop};
            mul_valid_reg <= div_valid_reg[DIV_STAGES];
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                div_reg[k] <= div_next[k];
            end
            for (int i = 0; i < pleev_pkg::LANES; i++)
            begin
                prod_reg[i] <= prod_next[i];
                base_reg[i] <= pa[i];
                up_reg[i]   <= up_next[i];
                res_reg[i]  <= res_next[i];
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.red_out   = res_reg[0][pleev_pkg::BYTE_W-1:0];
    assign result.green_out = res_reg[1][pleev_pkg::BYTE_W-1:0];
    assign result.blue_out  = res_reg[2][pleev_pkg::BYTE_W-1:0];
    assign result.alpha_out = res_reg[3][pleev_pkg::BYTE_W-1:0];
    assign result.width_out = res_reg[pleev_pkg::WIDTH_LANE];

endmodule

/* src/particle_life_envelope_eval_unit.sv */
// top level of the particle life envelope evaluator
// a request passes a queue entry, the load and 16 stages of the pipelined fraction
// divider, product and result registers; throughput: one request per cycle unless
// result stalls; a 4-entry queue decouples request acceptance from backpressure
// reset clears the queue, the pipeline valids and the configuration (life length 1)
`include "assert_macros.svh"

module particle_life_envelope_eval_unit (
    input logic            clk,
    input logic            rst_n,
    pleev_age_if.sink      age,
    pleev_cfg_if.sink      cfg,
    pleev_result_if.source result
);

    localparam int CAPACITY    = pleev_pkg::QUEUE_DEPTH + pleev_pkg::BLEND_FRACTION_BITS + 3;
    localparam int IN_FLIGHT_W = $clog2(CAPACITY + 1);

    pleev_pkg::cfg_t          cfg_reg;
    pleev_pkg::job_t          push_job;
    pleev_pkg::job_t          head;
    pleev_pkg::queue_status_t q_status;
    logic                     q_push;
    logic                     q_pop;
    logic [IN_FLIGHT_W-1:0]   in_flight_reg;
    logic [IN_FLIGHT_W-1:0]   in_flight_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.life_frames <= pleev_pkg::FRAMES_W'(1);
            cfg_reg.fade_frames <= '0;
            cfg_reg.colour_env  <= '0;
            cfg_reg.width_life  <= '0;
            cfg_reg.width_fade  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (pleev_pkg::cfg_index_t'(cfg.index))
                pleev_pkg::CFG_LIFE_FRAMES:
                    cfg_reg.life_frames <= cfg.data[pleev_pkg::FRAMES_W-1:0];
                pleev_pkg::CFG_FADE_FRAMES:
                    cfg_reg.fade_frames <= cfg.data[pleev_pkg::FRAMES_W-1:0];
                pleev_pkg::CFG_RED_ENVELOPE:
                    cfg_reg.colour_env[0] <= cfg.data[pleev_pkg::POINT_W-1:0];
                pleev_pkg::CFG_GREEN_ENVELOPE:
                    cfg_reg.colour_env[1] <= cfg.data[pleev_pkg::POINT_W-1:0];
                pleev_pkg::CFG_BLUE_ENVELOPE:
                    cfg_reg.colour_env[2] <= cfg.data[pleev_pkg::POINT_W-1:0];
                pleev_pkg::CFG_ALPHA_ENVELOPE:
                    cfg_reg.colour_env[3] <= cfg.data[pleev_pkg::POINT_W-1:0];
                pleev_pkg::CFG_WIDTH_LIFE_POINTS:
                    cfg_reg.width_life <= cfg.data;
                pleev_pkg::CFG_WIDTH_FADE_POINTS:
                    cfg_reg.width_fade <= cfg.data;
            endcase
        end
    end

    pleev_front u_front (
        .age      (age),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .push     (q_push),
        .job      (push_job)
    );

    pleev_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (head),
        .status   (q_status)
    );

    pleev_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .head     (head),
        .pop      (q_pop),
        .result   (result)
    );

    // requests accepted but not yet delivered
    always_comb
    begin
        in_flight_next = in_flight_reg;
        if ((age.valid && age.ready) && !(result.valid && result.ready))
        begin
            in_flight_next = in_flight_reg + 1'b1;
        end
        else if (!(age.valid && age.ready) && (result.valid && result.ready))
        begin
            in_flight_next = in_flight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight_reg <= '0;
        end
        else
        begin
            in_flight_reg <= in_flight_next;
        end
    end

    `PLEEV_ASSERT(a_pop_not_empty, q_pop |-> !q_status.empty, "queue popped while empty")
    `PLEEV_ASSERT(a_result_has_request, result.valid |-> in_flight_reg != '0, "orphan result")
    `PLEEV_ASSERT(a_in_flight_bound, in_flight_reg <= IN_FLIGHT_W'(CAPACITY), "in-flight overflow")
    `PLEEV_ASSERT_NEXT(a_full_holds, q_status.full && !q_pop, q_status.full, "full queue drained")

endmodule
